// ----- rtl/trt_pkg.sv -----
// ----------------------------------------------------------------------------
// trt_pkg
// Shared widths, reset values, codes and the multiply-accumulate program of
// the tagged range trilateration block.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int DIST_WIDTH     = 16;
  localparam int RAW_WIDTH      = 20;
  localparam int POS_WIDTH      = 32;
  localparam int RATE_WIDTH     = 8;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = (COORD_WIDTH > RATE_WIDTH) ? COORD_WIDTH : RATE_WIDTH;

  // datapath of the solver: 64-bit two's complement, multiplied in two halves
  localparam int ACC_WIDTH   = 64;
  localparam int HALF_WIDTH  = ACC_WIDTH / 2;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int OPND_WIDTH  = (DIFF_WIDTH > DIST_WIDTH + 1) ? DIFF_WIDTH : DIST_WIDTH + 1;
  localparam int PROD_WIDTH  = HALF_WIDTH + 1 + OPND_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(ACC_WIDTH);

  // reading split: quotient by ten through a reciprocal multiply
  localparam int TAG_WIDTH   = 4;
  localparam int QUOT_WIDTH  = RAW_WIDTH - 3;
  localparam int DCMP_WIDTH  = (QUOT_WIDTH > DIST_WIDTH) ? QUOT_WIDTH : DIST_WIDTH;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_MULT  = (2**RECIP_SHIFT + 9) / 10;
  localparam int RECIP_WIDTH = $clog2(RECIP_MULT + 1);
  localparam int RPROD_WIDTH = RAW_WIDTH + RECIP_WIDTH;

  localparam logic [TAG_WIDTH-1:0]  TAG_A    = TAG_WIDTH'(1);
  localparam logic [TAG_WIDTH-1:0]  TAG_B    = TAG_WIDTH'(2);
  localparam logic [TAG_WIDTH-1:0]  TAG_C    = TAG_WIDTH'(3);
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  localparam int OP_COUNT     = 18;
  localparam int OP_IDX_WIDTH = $clog2(OP_COUNT);

  // saturation limits of a quotient magnitude
  localparam logic [ACC_WIDTH-1:0] POS_LIM_P = ACC_WIDTH'({1'b0, {(POS_WIDTH-1){1'b1}}});
  localparam logic [ACC_WIDTH-1:0] POS_LIM_N = ACC_WIDTH'({1'b1, {(POS_WIDTH-1){1'b0}}});
  localparam logic [ACC_WIDTH-1:0] ACC_MIN   = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  localparam logic [COORD_WIDTH-1:0] AX_RESET   = COORD_WIDTH'(4370);
  localparam logic [COORD_WIDTH-1:0] AY_RESET   = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] BX_RESET   = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] BY_RESET   = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] CX_RESET   = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] CY_RESET   = COORD_WIDTH'(5590);
  localparam logic [RATE_WIDTH-1:0]  RATE_RESET = RATE_WIDTH'(5);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_AX,
    CFG_AY,
    CFG_BX,
    CFG_BY,
    CFG_CX,
    CFG_CY,
    CFG_RATE
  } cfg_idx_e;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] da;
    logic [DIST_WIDTH-1:0] db;
    logic [DIST_WIDTH-1:0] dc;
  } dist_set_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH-1:0] bx;
    logic [COORD_WIDTH-1:0] by;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
  } anchors_t;

  typedef enum logic [3:0] {
    OPD_AX,
    OPD_AY,
    OPD_BX,
    OPD_BY,
    OPD_CX,
    OPD_CY,
    OPD_DA,
    OPD_DB,
    OPD_DC,
    OPD_DIFF_A,
    OPD_DIFF_B,
    OPD_DIFF_D,
    OPD_DIFF_E
  } opnd_e;

  typedef enum logic [2:0] {
    XS_SQUARE,
    XS_DIFF_A,
    XS_DIFF_B,
    XS_REG_C,
    XS_REG_F
  } xsel_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_C,
    DST_F,
    DST_DEN,
    DST_NUM_X,
    DST_NUM_Y
  } dst_e;

  typedef struct packed {
    xsel_e xsel;
    opnd_e ysel;
    logic  sub;
    dst_e  dst;
  } mac_op_t;

  typedef struct packed {
    logic start;
    logic neg_den;
  } div_ctrl_t;

  // one product per step, added to or subtracted from the accumulator, stored at a named target
  function automatic mac_op_t mac_program(input logic [OP_IDX_WIDTH-1:0] idx);
    mac_op_t op;
    case (idx)
      0:       op = '{XS_SQUARE, OPD_AX,     1'b0, DST_NONE};
      1:       op = '{XS_SQUARE, OPD_CX,     1'b1, DST_NONE};
      2:       op = '{XS_SQUARE, OPD_AY,     1'b0, DST_NONE};
      3:       op = '{XS_SQUARE, OPD_CY,     1'b1, DST_NONE};
      4:       op = '{XS_SQUARE, OPD_DC,     1'b0, DST_NONE};
      5:       op = '{XS_SQUARE, OPD_DA,     1'b1, DST_C};
      6:       op = '{XS_SQUARE, OPD_BX,     1'b0, DST_NONE};
      7:       op = '{XS_SQUARE, OPD_CX,     1'b1, DST_NONE};
      8:       op = '{XS_SQUARE, OPD_BY,     1'b0, DST_NONE};
      9:       op = '{XS_SQUARE, OPD_CY,     1'b1, DST_NONE};
      10:      op = '{XS_SQUARE, OPD_DC,     1'b0, DST_NONE};
      11:      op = '{XS_SQUARE, OPD_DB,     1'b1, DST_F};
      12:      op = '{XS_DIFF_B, OPD_DIFF_D, 1'b0, DST_NONE};
      13:      op = '{XS_DIFF_A, OPD_DIFF_E, 1'b1, DST_DEN};
      14:      op = '{XS_REG_F,  OPD_DIFF_B, 1'b0, DST_NONE};
      15:      op = '{XS_REG_C,  OPD_DIFF_E, 1'b1, DST_NUM_X};
      16:      op = '{XS_REG_F,  OPD_DIFF_A, 1'b0, DST_NONE};
      17:      op = '{XS_REG_C,  OPD_DIFF_D, 1'b1, DST_NUM_Y};
      default: op = '{XS_SQUARE, OPD_AX,     1'b0, DST_NONE};
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/tagged_range_trilateration.sv -----
// ----------------------------------------------------------------------------
// tagged_range_trilateration
// Range readings in, 2-D positions against three configured anchors out.
// ----------------------------------------------------------------------------
// A reading is accepted when the input is not stalled and updates the stored
// range that its tag names; a reading that does not call for a position costs
// nothing more. When a position is due, the ranges go into a two-entry queue
// and a solver works on them: multiply-accumulate steps on one shared 33 by 17
// bit multiplier, then two 64-step divisions (no divisions when the anchors
// are collinear). The front keeps taking readings while the queue has room.
// Configuration writes are always ready and take effect at once; they are
// meant for an idle block.
module tagged_range_trilateration (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [trt_pkg::RAW_WIDTH-1:0]         raw_reading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [trt_pkg::POS_WIDTH-1:0]  pos_x_o,
  output logic signed [trt_pkg::POS_WIDTH-1:0]  pos_y_o,
  output logic                                  degenerate_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [trt_pkg::CFG_IDX_WIDTH-1:0]     cfg_index_i,
  input  logic [trt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data_i
);

  trt_pkg::anchors_t                    anchors_q;
  logic [trt_pkg::RATE_WIDTH-1:0]       rate_q;
  logic                                 cfg_write;

  logic                                 push, full, pop, empty;
  trt_pkg::dist_set_t                   push_data, pop_data;
  logic [trt_pkg::POS_WIDTH-1:0]        pos_x, pos_y;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchors_q.ax <= trt_pkg::AX_RESET;
      anchors_q.ay <= trt_pkg::AY_RESET;
      anchors_q.bx <= trt_pkg::BX_RESET;
      anchors_q.by <= trt_pkg::BY_RESET;
      anchors_q.cx <= trt_pkg::CX_RESET;
      anchors_q.cy <= trt_pkg::CY_RESET;
      rate_q       <= trt_pkg::RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        trt_pkg::CFG_AX:   anchors_q.ax <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_AY:   anchors_q.ay <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_BX:   anchors_q.bx <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_BY:   anchors_q.by <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_CX:   anchors_q.cx <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_CY:   anchors_q.cy <= cfg_data_i[trt_pkg::COORD_WIDTH-1:0];
        trt_pkg::CFG_RATE: rate_q       <= cfg_data_i[trt_pkg::RATE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  trt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_reading_i  (raw_reading_i),
    .rate_divider_i (rate_q),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  trt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  trt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .anchors_i    (anchors_q),
    .empty_i      (empty),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .degenerate_o (degenerate_o)
  );

  assign pos_x_o = $signed(pos_x);
  assign pos_y_o = $signed(pos_y);

endmodule

// ----- rtl/trt_front.sv -----
// ----------------------------------------------------------------------------
// trt_front
// Takes readings, splits them into distance and tag, keeps the three ranges
// and the emit counter, and queues a range snapshot when a position is due.
// ----------------------------------------------------------------------------
module trt_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [trt_pkg::RAW_WIDTH-1:0]     raw_reading_i,
  input  logic [trt_pkg::RATE_WIDTH-1:0]    rate_divider_i,
  input  logic                              full_i,
  output logic                              push_o,
  output trt_pkg::dist_set_t                push_data_o
);

  logic                                 accept;
  logic                                 emit;
  logic [trt_pkg::RPROD_WIDTH-1:0]      recip_prod;
  logic [trt_pkg::QUOT_WIDTH-1:0]       quot;
  logic [trt_pkg::RAW_WIDTH-1:0]        quot_x10;
  logic [trt_pkg::TAG_WIDTH-1:0]        tag;
  logic [trt_pkg::DCMP_WIDTH-1:0]       quot_ext;
  logic [trt_pkg::DIST_WIDTH-1:0]       dist_new;
  trt_pkg::dist_set_t                   dist_q, dist_d;
  logic [trt_pkg::RATE_WIDTH-1:0]       count_q, count_d;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // exact quotient by ten for every reading width in use
  assign recip_prod = trt_pkg::RPROD_WIDTH'(raw_reading_i)
                    * trt_pkg::RPROD_WIDTH'(trt_pkg::RECIP_MULT);
  assign quot       = recip_prod[trt_pkg::RECIP_SHIFT +: trt_pkg::QUOT_WIDTH];
  assign quot_x10   = trt_pkg::RAW_WIDTH'({quot, 3'b000})
                    + trt_pkg::RAW_WIDTH'({quot, 1'b0});
  assign tag        = trt_pkg::TAG_WIDTH'(raw_reading_i - quot_x10);
  assign quot_ext   = trt_pkg::DCMP_WIDTH'(quot);
  assign dist_new   = (quot_ext > trt_pkg::DCMP_WIDTH'(trt_pkg::DIST_MAX)) ?
                      trt_pkg::DIST_MAX : trt_pkg::DIST_WIDTH'(quot_ext);

  assign emit = accept && (count_q == rate_divider_i);

  always_comb begin
    dist_d  = dist_q;
    count_d = count_q;
    if (accept) begin
      unique case (tag)
        trt_pkg::TAG_A: dist_d.da = dist_new;
        trt_pkg::TAG_B: dist_d.db = dist_new;
        trt_pkg::TAG_C: dist_d.dc = dist_new;
        default: ;
      endcase
      count_d = emit ? '0 : count_q + 1'b1;
    end
  end

  assign push_o      = emit;
  assign push_data_o = dist_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= '0;
      count_q <= '0;
    end else begin
      dist_q  <= dist_d;
      count_q <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_emit_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> count_q == '0)
    else $error("emit counter not cleared after a position was queued");
`endif

endmodule

// ----- rtl/trt_fifo.sv -----
// ----------------------------------------------------------------------------
// trt_fifo
// Short queue of range snapshots between the front and the solver.
// ----------------------------------------------------------------------------
module trt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  trt_pkg::dist_set_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output trt_pkg::dist_set_t pop_data_o
);

  trt_pkg::dist_set_t                    mem_q [trt_pkg::FIFO_DEPTH];
  logic [trt_pkg::FIFO_PTR_WIDTH-1:0]    wr_ptr_q, rd_ptr_q;
  logic [trt_pkg::FIFO_CNT_WIDTH-1:0]    count_q;
  logic                                  do_push, do_pop;

  assign full_o     = (count_q == trt_pkg::FIFO_CNT_WIDTH'(trt_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == trt_pkg::FIFO_PTR_WIDTH'(trt_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == trt_pkg::FIFO_PTR_WIDTH'(trt_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("snapshot pushed into a full queue");
`endif

endmodule

// ----- rtl/trt_div.sv -----
// ----------------------------------------------------------------------------
// trt_div
// Signed 64-bit division, truncating toward zero, one quotient bit per cycle,
// with the quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module trt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trt_pkg::div_ctrl_t                ctrl_i,
  input  logic [trt_pkg::ACC_WIDTH-1:0]     num_i,
  input  logic [trt_pkg::ACC_WIDTH-1:0]     den_i,
  output logic                              done_o,
  output logic [trt_pkg::POS_WIDTH-1:0]     quot_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } div_state_e;

  div_state_e                           state_q;
  logic [trt_pkg::ACC_WIDTH-1:0]        dvd_q, rem_q, dsr_q;
  logic [trt_pkg::DIV_CNT_WIDTH-1:0]    cnt_q;
  logic                                 neg_q;
  logic                                 done_q;
  logic [trt_pkg::POS_WIDTH-1:0]        quot_q;

  logic                                 num_neg, den_neg;
  logic [trt_pkg::ACC_WIDTH-1:0]        num_mag, den_mag;
  logic [trt_pkg::ACC_WIDTH:0]          trial, trial_sub;
  logic                                 trial_ge;
  logic [trt_pkg::POS_WIDTH-1:0]        sat_res;

  // sign of the divisor after an optional negation, most negative value stays negative
  assign num_neg = num_i[trt_pkg::ACC_WIDTH-1];
  assign den_neg = ctrl_i.neg_den ?
                   (~den_i[trt_pkg::ACC_WIDTH-1] | (den_i == trt_pkg::ACC_MIN)) :
                   den_i[trt_pkg::ACC_WIDTH-1];
  assign num_mag = num_neg ? ('0 - num_i) : num_i;
  assign den_mag = den_i[trt_pkg::ACC_WIDTH-1] ? ('0 - den_i) : den_i;

  assign trial     = {rem_q, dvd_q[trt_pkg::ACC_WIDTH-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign trial_ge  = ~trial_sub[trt_pkg::ACC_WIDTH];

  always_comb begin
    if (neg_q) begin
      if (dvd_q > trt_pkg::POS_LIM_N) begin
        sat_res = trt_pkg::POS_WIDTH'(trt_pkg::POS_LIM_N);
      end else begin
        sat_res = '0 - dvd_q[trt_pkg::POS_WIDTH-1:0];
      end
    end else begin
      if (dvd_q > trt_pkg::POS_LIM_P) begin
        sat_res = trt_pkg::POS_WIDTH'(trt_pkg::POS_LIM_P);
      end else begin
        sat_res = dvd_q[trt_pkg::POS_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      quot_q  <= '0;
    end else begin
      done_q <= (state_q == D_FIN);
      unique case (state_q)
        D_IDLE: begin
          if (ctrl_i.start) begin
            dvd_q   <= num_mag;
            dsr_q   <= den_mag;
            rem_q   <= '0;
            cnt_q   <= '0;
            neg_q   <= num_neg ^ den_neg;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          // dividend shifts out at the top while quotient bits enter at the bottom
          rem_q <= trial_ge ? trial_sub[trt_pkg::ACC_WIDTH-1:0] :
                              trial[trt_pkg::ACC_WIDTH-1:0];
          dvd_q <= {dvd_q[trt_pkg::ACC_WIDTH-2:0], trial_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == trt_pkg::DIV_CNT_WIDTH'(trt_pkg::ACC_WIDTH - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          quot_q  <= sat_res;
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("division done held for more than one cycle");
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> state_q == D_IDLE)
    else $error("division started while one is in progress");
`endif

endmodule

// ----- rtl/trt_back.sv -----
// ----------------------------------------------------------------------------
// trt_back
// Solver: takes a range snapshot, forms the trilateration terms on one shared
// multiplier with an accumulator, then runs the two divisions unless the anchors are collinear.
// ----------------------------------------------------------------------------
module trt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trt_pkg::anchors_t                 anchors_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  trt_pkg::dist_set_t                pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [trt_pkg::POS_WIDTH-1:0]     pos_x_o,
  output logic [trt_pkg::POS_WIDTH-1:0]     pos_y_o,
  output logic                              degenerate_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_CHECK,
    S_DIV_X,
    S_START_Y,
    S_DIV_Y,
    S_LOAD
  } back_state_e;

  back_state_e                            state_q;
  trt_pkg::dist_set_t                     dist_q;
  logic [trt_pkg::OP_IDX_WIDTH-1:0]       op_idx_q;
  logic                                   phase_q;
  logic [trt_pkg::ACC_WIDTH-1:0]          term_q;
  logic                                   term_vld_q;
  logic                                   term_sub_q;
  trt_pkg::dst_e                          term_dst_q;
  logic [trt_pkg::ACC_WIDTH-1:0]          acc_q, c_q, f_q, den_q, nx_q, ny_q;
  logic [trt_pkg::POS_WIDTH-1:0]          res_x_q, res_y_q;
  logic                                   res_deg_q;
  logic                                   out_valid_q;
  logic [trt_pkg::POS_WIDTH-1:0]          pos_x_q, pos_y_q;
  logic                                   deg_q;

  trt_pkg::mac_op_t                       op;
  logic signed [trt_pkg::DIFF_WIDTH-1:0]  diff_a, diff_b, diff_d, diff_e;
  logic signed [trt_pkg::OPND_WIDTH-1:0]  y_opnd;
  logic [trt_pkg::ACC_WIDTH-1:0]          x_opnd;
  logic [trt_pkg::HALF_WIDTH-1:0]         x_half;
  logic signed [trt_pkg::PROD_WIDTH-1:0]  prod;
  logic [trt_pkg::ACC_WIDTH-1:0]          term_next;
  logic [trt_pkg::ACC_WIDTH-1:0]          acc_sum;
  logic                                   out_free;
  trt_pkg::div_ctrl_t                     div_ctrl;
  logic                                   div_done;
  logic [trt_pkg::POS_WIDTH-1:0]          div_quot;

  assign op = trt_pkg::mac_program(op_idx_q);

  assign diff_a = trt_pkg::DIFF_WIDTH'($signed(anchors_i.ax))
                - trt_pkg::DIFF_WIDTH'($signed(anchors_i.cx));
  assign diff_b = trt_pkg::DIFF_WIDTH'($signed(anchors_i.ay))
                - trt_pkg::DIFF_WIDTH'($signed(anchors_i.cy));
  assign diff_d = trt_pkg::DIFF_WIDTH'($signed(anchors_i.bx))
                - trt_pkg::DIFF_WIDTH'($signed(anchors_i.cx));
  assign diff_e = trt_pkg::DIFF_WIDTH'($signed(anchors_i.by))
                - trt_pkg::DIFF_WIDTH'($signed(anchors_i.cy));

  always_comb begin
    unique case (op.ysel)
      trt_pkg::OPD_AX:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.ax));
      trt_pkg::OPD_AY:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.ay));
      trt_pkg::OPD_BX:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.bx));
      trt_pkg::OPD_BY:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.by));
      trt_pkg::OPD_CX:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.cx));
      trt_pkg::OPD_CY:     y_opnd = trt_pkg::OPND_WIDTH'($signed(anchors_i.cy));
      trt_pkg::OPD_DA:     y_opnd = $signed(trt_pkg::OPND_WIDTH'(dist_q.da));
      trt_pkg::OPD_DB:     y_opnd = $signed(trt_pkg::OPND_WIDTH'(dist_q.db));
      trt_pkg::OPD_DC:     y_opnd = $signed(trt_pkg::OPND_WIDTH'(dist_q.dc));
      trt_pkg::OPD_DIFF_A: y_opnd = trt_pkg::OPND_WIDTH'(diff_a);
      trt_pkg::OPD_DIFF_B: y_opnd = trt_pkg::OPND_WIDTH'(diff_b);
      trt_pkg::OPD_DIFF_D: y_opnd = trt_pkg::OPND_WIDTH'(diff_d);
      trt_pkg::OPD_DIFF_E: y_opnd = trt_pkg::OPND_WIDTH'(diff_e);
      default:             y_opnd = '0;
    endcase
  end

  always_comb begin
    unique case (op.xsel)
      trt_pkg::XS_SQUARE: x_opnd = trt_pkg::ACC_WIDTH'(y_opnd);
      trt_pkg::XS_DIFF_A: x_opnd = trt_pkg::ACC_WIDTH'(diff_a);
      trt_pkg::XS_DIFF_B: x_opnd = trt_pkg::ACC_WIDTH'(diff_b);
      trt_pkg::XS_REG_C:  x_opnd = c_q;
      trt_pkg::XS_REG_F:  x_opnd = f_q;
      default:            x_opnd = '0;
    endcase
  end

  // wide operand in two unsigned halves, product kept modulo 2^64
  assign x_half    = phase_q ? x_opnd[trt_pkg::ACC_WIDTH-1:trt_pkg::HALF_WIDTH] :
                               x_opnd[trt_pkg::HALF_WIDTH-1:0];
  assign prod      = $signed({1'b0, x_half}) * y_opnd;
  assign term_next = phase_q ? {prod[trt_pkg::HALF_WIDTH-1:0], trt_pkg::HALF_WIDTH'(0)} :
                               trt_pkg::ACC_WIDTH'(prod);

  assign acc_sum = term_sub_q ? (acc_q - term_q) : (acc_q + term_q);

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = (state_q == S_IDLE) & ~empty_i;

  assign div_ctrl.start   = ((state_q == S_CHECK) && (den_q != '0)) || (state_q == S_START_Y);
  assign div_ctrl.neg_den = (state_q == S_START_Y);

  trt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  ((state_q == S_START_Y) ? ny_q : nx_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dist_q      <= '0;
      op_idx_q    <= '0;
      phase_q     <= 1'b0;
      term_q      <= '0;
      term_vld_q  <= 1'b0;
      term_sub_q  <= 1'b0;
      term_dst_q  <= trt_pkg::DST_NONE;
      acc_q       <= '0;
      c_q         <= '0;
      f_q         <= '0;
      den_q       <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      res_deg_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      deg_q       <= 1'b0;
    end else begin
      // accumulate stage, fed by the product registered in term_q
      if (term_vld_q) begin
        if (term_dst_q == trt_pkg::DST_NONE) begin
          acc_q <= acc_sum;
        end else begin
          acc_q <= '0;
          unique case (term_dst_q)
            trt_pkg::DST_C:     c_q   <= acc_sum;
            trt_pkg::DST_F:     f_q   <= acc_sum;
            trt_pkg::DST_DEN:   den_q <= {acc_sum[trt_pkg::ACC_WIDTH-2:0], 1'b0};
            trt_pkg::DST_NUM_X: nx_q  <= acc_sum;
            trt_pkg::DST_NUM_Y: ny_q  <= acc_sum;
            default: ;
          endcase
        end
      end

      // the load state refills the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end

      term_vld_q <= (state_q == S_MAC);
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            dist_q   <= pop_data_i;
            acc_q    <= '0;
            op_idx_q <= '0;
            phase_q  <= 1'b0;
            state_q  <= S_MAC;
          end
        end
        S_MAC: begin
          term_q     <= term_next;
          term_sub_q <= op.sub;
          term_dst_q <= phase_q ? op.dst : trt_pkg::DST_NONE;
          phase_q    <= ~phase_q;
          if (phase_q) begin
            if (op_idx_q == trt_pkg::OP_IDX_WIDTH'(trt_pkg::OP_COUNT - 1)) begin
              state_q <= S_DRAIN;
            end else begin
              op_idx_q <= op_idx_q + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          // collinear anchors give zeros and the flag
          if (den_q == '0) begin
            res_x_q   <= '0;
            res_y_q   <= '0;
            res_deg_q <= 1'b1;
            state_q   <= S_LOAD;
          end else begin
            state_q <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            res_x_q <= div_quot;
            state_q <= S_START_Y;
          end
        end
        S_START_Y: begin
          state_q <= S_DIV_Y;
        end
        S_DIV_Y: begin
          if (div_done) begin
            res_y_q   <= div_quot;
            res_deg_q <= 1'b0;
            state_q   <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            pos_x_q     <= res_x_q;
            pos_y_q     <= res_y_q;
            deg_q       <= res_deg_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign degenerate_o = deg_q;

`ifndef ASSERT_OFF
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && deg_q) |-> (pos_x_q == '0 && pos_y_q == '0))
    else $error("degenerate result carries a nonzero position");
`endif

endmodule

// ----- dv/tb_tagged_range_trilateration.sv -----
// ----------------------------------------------------------------------------
// tb_tagged_range_trilateration
// Self-checking bench for the tagged range trilateration block: a directed
// table of readings and register writes, then randomized phases of anchor and
// rate settings with tagged readings. A behavioral position tracker predicts
// each fix not in the table; the scoreboard compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_tagged_range_trilateration;

  import trt_pkg::*;

  localparam int          NUM_DIR       = 40;
  localparam int          RANDOM_ITEMS  = 1380;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          HOLD_PHASE    = 3;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  // register index past the end of the register file, must be ignored
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE = CFG_IDX_WIDTH'(7);

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] x;
    logic signed [POS_WIDTH-1:0] y;
    logic                        deg;
  } position_t;

  typedef enum logic {ROW_READ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_WIDTH-1:0]   idx;
    logic [CFG_DATA_WIDTH-1:0]  data;
    logic [RAW_WIDTH-1:0]       raw;
    logic                       typed;
    position_t                  want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [RAW_WIDTH-1:0]          raw_reading_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [POS_WIDTH-1:0]   pos_x_o;
  logic signed [POS_WIDTH-1:0]   pos_y_o;
  logic                          degenerate_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data_i = '0;

  // tracker state
  anchors_t                      anchors;
  dist_set_t                     ranges;
  logic [RATE_WIDTH-1:0]         rate_div;
  logic [RATE_WIDTH-1:0]         emit_cnt;
  position_t                     pending_fixes [$];

  cfg_idx_e                      coord_reg [6] = '{CFG_AX, CFG_AY, CFG_BX, CFG_BY, CFG_CX,
                                                   CFG_CY};
  dir_row_t                      dir_rows [NUM_DIR];
  logic [7:0]                    hold_token = '0;
  logic [7:0]                    hold_seen = '0;
  logic                          quiet = 1'b0;
  int unsigned                   stall_left = 0;
  int unsigned                   stall_roll;
  int unsigned                   cycle_count = 0;
  int unsigned                   mismatches = 0;

  tagged_range_trilateration u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_reading_i (raw_reading_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .degenerate_o  (degenerate_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tagged_range_trilateration verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tracker

  function automatic logic [ACC_WIDTH-1:0] widen(input logic [COORD_WIDTH-1:0] v);
    return {{(ACC_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  // truncating signed divide, magnitude clamped to the 32-bit range
  function automatic logic [POS_WIDTH-1:0] fix_quotient(input logic [ACC_WIDTH-1:0] num,
                                                        input logic [ACC_WIDTH-1:0] den);
    logic [ACC_WIDTH-1:0] mag_n, mag_d, q;
    mag_n = num[ACC_WIDTH-1] ? -num : num;
    mag_d = den[ACC_WIDTH-1] ? -den : den;
    q = mag_n / mag_d;
    if (num[ACC_WIDTH-1] != den[ACC_WIDTH-1]) begin
      if (q > POS_LIM_N) q = POS_LIM_N;
      q = -q;
    end else if (q > POS_LIM_P) begin
      q = POS_LIM_P;
    end
    return q[POS_WIDTH-1:0];
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_WIDTH-1:0] idx,
                                       input logic [CFG_DATA_WIDTH-1:0] data);
    case (idx)
      CFG_AX:   anchors.ax = data[COORD_WIDTH-1:0];
      CFG_AY:   anchors.ay = data[COORD_WIDTH-1:0];
      CFG_BX:   anchors.bx = data[COORD_WIDTH-1:0];
      CFG_BY:   anchors.by = data[COORD_WIDTH-1:0];
      CFG_CX:   anchors.cx = data[COORD_WIDTH-1:0];
      CFG_CY:   anchors.cy = data[COORD_WIDTH-1:0];
      CFG_RATE: rate_div   = data[RATE_WIDTH-1:0];
      default:  ;
    endcase
  endfunction

  // updates the ranges, returns 1 with the fix when a position is due
  function automatic logic track_position(input logic [RAW_WIDTH-1:0] raw,
                                          output position_t fix);
    logic [RAW_WIDTH-1:0]  quo;
    logic [TAG_WIDTH-1:0]  tag;
    logic [DIST_WIDTH-1:0] range_new;
    logic [ACC_WIDTH-1:0]  ax, ay, bx, by_w, cx, cy, da, db, dc;
    logic [ACC_WIDTH-1:0]  dx_ac, dy_ac, dx_bc, dy_bc, rhs_a, rhs_b, den;
    fix = '0;
    quo = raw / RAW_WIDTH'(10);
    tag = TAG_WIDTH'(raw % RAW_WIDTH'(10));
    range_new = (quo > RAW_WIDTH'(DIST_MAX)) ? DIST_MAX : quo[DIST_WIDTH-1:0];
    if (tag == TAG_A) ranges.da = range_new;
    else if (tag == TAG_B) ranges.db = range_new;
    else if (tag == TAG_C) ranges.dc = range_new;
    if (emit_cnt != rate_div) begin
      emit_cnt = emit_cnt + 1'b1;
      return 1'b0;
    end
    emit_cnt = '0;
    ax = widen(anchors.ax);
    ay = widen(anchors.ay);
    bx = widen(anchors.bx);
    by_w = widen(anchors.by);
    cx = widen(anchors.cx);
    cy = widen(anchors.cy);
    da = ACC_WIDTH'(ranges.da);
    db = ACC_WIDTH'(ranges.db);
    dc = ACC_WIDTH'(ranges.dc);
    dx_ac = ax - cx;
    dy_ac = ay - cy;
    dx_bc = bx - cx;
    dy_bc = by_w - cy;
    rhs_a = ax * ax - cx * cx + ay * ay - cy * cy + dc * dc - da * da;
    rhs_b = bx * bx - cx * cx + by_w * by_w - cy * cy + dc * dc - db * db;
    den = ACC_WIDTH'(2) * dy_ac * dx_bc - ACC_WIDTH'(2) * dx_ac * dy_bc;
    if (den == '0) begin
      fix.deg = 1'b1;
    end else begin
      fix.x = fix_quotient(dy_ac * rhs_b - dy_bc * rhs_a, den);
      fix.y = fix_quotient(dx_ac * rhs_b - dx_bc * rhs_a, -den);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic dir_row_t read_row(input logic [RAW_WIDTH-1:0] raw);
    return '{ROW_READ, CFG_AX, '0, raw, 1'b0, '0};
  endfunction

  function automatic dir_row_t fix_row(input logic [RAW_WIDTH-1:0] raw,
                                       input logic signed [POS_WIDTH-1:0] x,
                                       input logic signed [POS_WIDTH-1:0] y,
                                       input logic deg);
    return '{ROW_READ, CFG_AX, '0, raw, 1'b1, '{x, y, deg}};
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_WIDTH-1:0] idx,
                                       input logic [CFG_DATA_WIDTH-1:0] data);
    return '{ROW_CFG, idx, data, '0, 1'b0, '0};
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_reading(input logic [RAW_WIDTH-1:0] raw, input logic typed,
                              input position_t want);
    int unsigned gap;
    position_t   fix;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_reading_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    if (track_position(raw, fix)) pending_fixes.push_back(typed ? want : fix);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_config(idx, data);
  endtask

  // solver may still be busy after the last fix, so rest a full solve time
  task automatic rest_until_idle();
    in_valid_i <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    position_t exp_fix;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected transfer x=%0d y=%0d degenerate=%0b", $time, pos_x_o,
                 pos_y_o, degenerate_o);
        mismatches = mismatches + 1;
      end else begin
        exp_fix = pending_fixes.pop_front();
        if (pos_x_o !== exp_fix.x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, exp_fix.x, pos_x_o);
          mismatches = mismatches + 1;
        end
        if (pos_y_o !== exp_fix.y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, exp_fix.y, pos_y_o);
          mismatches = mismatches + 1;
        end
        if (degenerate_o !== exp_fix.deg) begin
          $display("%0t: degenerate expected %0b got %0b", $time, exp_fix.deg, degenerate_o);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int unsigned              i;
    int unsigned              k;
    int unsigned              n;
    int unsigned              sent;
    int unsigned              phase;
    int unsigned              range_val;
    logic [COORD_WIDTH-1:0]   crd [6];
    logic [RATE_WIDTH-1:0]    rate;
    logic [TAG_WIDTH-1:0]     tag;

    anchors = '{AX_RESET, AY_RESET, BX_RESET, BY_RESET, CX_RESET, CY_RESET};
    ranges = '0;
    rate_div = RATE_RESET;
    emit_cnt = '0;

    dir_rows = '{
      // zero ranges after reset, unknown tags, largest range
      read_row(1), read_row(2), read_row(3), read_row(0), read_row(655359),
      fix_row(655354, 2185, 2795, 1'b0),
      // upper data bits are dropped, rate becomes zero
      reg_row(CFG_RATE, 16'ha500),
      read_row(655351), read_row(655352), read_row(655353),
      // all anchors at the origin: collinear
      reg_row(CFG_AX, 16'h0000), reg_row(CFG_AY, 16'h0000), reg_row(CFG_BX, 16'h0000),
      reg_row(CFG_BY, 16'h0000), reg_row(CFG_CX, 16'h0000), reg_row(CFG_CY, 16'h0000),
      fix_row(5, 0, 0, 1'b1),
      // coordinate extremes
      reg_row(CFG_AX, 16'h8000), reg_row(CFG_AY, 16'h7fff), reg_row(CFG_BX, 16'h7fff),
      reg_row(CFG_BY, 16'h8000), reg_row(CFG_CX, 16'h8000), reg_row(CFG_CY, 16'h8000),
      read_row(655357), read_row(11),
      // tiny denominator, quotients clamp both ways
      reg_row(CFG_AX, 16'h7fff), reg_row(CFG_AY, 16'h0001), reg_row(CFG_BX, 16'h0001),
      reg_row(CFG_BY, 16'h0000), reg_row(CFG_CX, 16'h0000), reg_row(CFG_CY, 16'h0000),
      read_row(2), read_row(3), read_row(655352),
      reg_row(CFG_SPARE, 16'hffff), read_row(6),
      // rate lowered below the running count, count wraps later
      reg_row(CFG_RATE, 16'h0003), read_row(4), read_row(7),
      reg_row(CFG_RATE, 16'h0001)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) rest_until_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (i == NUM_DIR - 1 || dir_rows[i+1].kind != ROW_CFG) cfg_valid_i <= 1'b0;
      end else begin
        send_reading(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      rest_until_idle();
      for (k = 0; k < 6; k++) crd[k] = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: for (k = 0; k < 6; k++) crd[k] = 16'($urandom_range(0, 10000) - 5000);
        5, 6: ;
        7: for (k = 0; k < 6; k++) crd[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        8: begin
          crd[3] = crd[1];
          crd[5] = crd[1];
        end
        default: begin
          crd[2] = crd[0];
          crd[4] = crd[0];
        end
      endcase
      for (k = 0; k < 6; k++) write_reg(coord_reg[k], crd[k]);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));

      case ($urandom_range(0, 9))
        0, 1, 2, 3: rate = '0;
        4, 5, 6, 7: rate = 8'($urandom_range(1, 7));
        8: rate = 8'($urandom_range(8, 31));
        default: rate = $urandom_range(0, 1) ? 8'hff : 8'($urandom_range(128, 254));
      endcase
      if (phase == HOLD_PHASE) rate = '0;
      // first phase keeps the lowered rate so the count has to wrap
      if (phase != 0) write_reg(CFG_RATE, {8'($urandom), rate});
      cfg_valid_i <= 1'b0;

      if (phase == 0) n = 300;
      else if (phase == HOLD_PHASE) n = 16;
      else if (rate >= 8'd128) n = $urandom_range(280, 400);
      else n = $urandom_range(40, 120);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;

      if (phase == HOLD_PHASE) hold_token <= hold_token + 1'b1;
      quiet <= (phase == HOLD_PHASE) || ($urandom_range(0, 4) == 0);

      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          case (k % 3)
            0: tag = TAG_A;
            1: tag = TAG_B;
            default: tag = TAG_C;
          endcase
        end else begin
          tag = TAG_WIDTH'($urandom_range(4, 10) % 10);
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: range_val = $urandom_range(0, 6000);
          6, 7: range_val = $urandom_range(0, 65535);
          8: range_val = 65535;
          default: range_val = 0;
        endcase
        send_reading(RAW_WIDTH'(range_val * 10 + tag), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    rest_until_idle();
    if (mismatches == 0) begin
      $display("tagged_range_trilateration verification clean");
    end else begin
      $display("tagged_range_trilateration verification failed");
    end
    $finish;
  end

endmodule
